/* rtl/arc_pkg.sv */
// -----------------------------------------------------------------------------
// Rate converter package
// Field widths, register indexes, reset values and the configuration bundle
// shared by the converter modules.
// -----------------------------------------------------------------------------
package arc_pkg;

	localparam int SampleW = 8;
	localparam int AccW    = 18;
	localparam int RateW   = 17;
	localparam int FrameW  = 6;
	localparam int LinesW  = 9;
	localparam int SpfW    = 14;
	localparam int SrcW    = 16;
	localparam int IdxW    = 3;
	localparam int NW      = 3;

	localparam logic [IdxW-1:0] RegOutputRate  = 3'd0;
	localparam logic [IdxW-1:0] RegFrameRate   = 3'd1;
	localparam logic [IdxW-1:0] RegLines       = 3'd2;
	localparam logic [IdxW-1:0] RegSpf         = 3'd3;
	localparam logic [IdxW-1:0] RegMixEnable   = 3'd4;

	localparam logic [RateW-1:0]  RstOutputRate = 17'd48000;
	localparam logic [FrameW-1:0] RstFrameRate  = 6'd60;
	localparam logic [LinesW-1:0] RstLines      = 9'd262;
	localparam logic [SpfW-1:0]   RstSpf        = 14'd800;

	localparam logic [16:0]     MaxFrameSamples = 17'd8192;
	localparam logic [NW-1:0]   EmitMax         = 3'd5;
	localparam logic [AccW-1:0] AccMax          = 18'h3FFFF;

	typedef struct packed {
		logic [RateW-1:0] output_rate;
		logic             mix_enable;
		logic [SrcW-1:0]  src_rate;
		logic [SpfW-1:0]  limit;
	} cfg_t;

endpackage

/* rtl/arc_addsub.sv */
// -----------------------------------------------------------------------------
// Shared adder/subtractor
// One accumulator-wide add or subtract with carry/borrow out, reused by the
// sequencer for the per-step phase advance and every emit test.
// -----------------------------------------------------------------------------
module arc_addsub (
	input  logic [arc_pkg::AccW-1:0] a,
	input  logic [arc_pkg::AccW-1:0] b,
	input  logic                     sub,
	output logic [arc_pkg::AccW:0]   res
);

	always_comb begin
		if (sub) begin
			res = {1'b0, a} - {1'b0, b};
		end else begin
			res = {1'b0, a} + {1'b0, b};
		end
	end

endmodule

/* rtl/arc_cfg_regs.sv */
// -----------------------------------------------------------------------------
// Rate converter register file
// Holds the five settings and registers the derived source rate and
// per-frame output limit.
// -----------------------------------------------------------------------------
module arc_cfg_regs (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [arc_pkg::IdxW-1:0] wr_index,
	input  logic [31:0]              wr_data,
	output arc_pkg::cfg_t            cfg
);

	logic [arc_pkg::RateW-1:0]  output_rate_q;
	logic [arc_pkg::FrameW-1:0] frame_rate_q;
	logic [arc_pkg::LinesW-1:0] lines_q;
	logic [arc_pkg::SpfW-1:0]   spf_q;
	logic                       mix_q;
	logic [arc_pkg::SrcW-1:0]   src_q;
	logic [arc_pkg::SpfW-1:0]   limit_q;
	logic [14:0]                prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_rate_q <= arc_pkg::RstOutputRate;
			frame_rate_q  <= arc_pkg::RstFrameRate;
			lines_q       <= arc_pkg::RstLines;
			spf_q         <= arc_pkg::RstSpf;
			mix_q         <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				arc_pkg::RegOutputRate: output_rate_q <= wr_data[arc_pkg::RateW-1:0];
				arc_pkg::RegFrameRate:  frame_rate_q  <= wr_data[arc_pkg::FrameW-1:0];
				arc_pkg::RegLines:      lines_q       <= wr_data[arc_pkg::LinesW-1:0];
				arc_pkg::RegSpf:        spf_q         <= wr_data[arc_pkg::SpfW-1:0];
				arc_pkg::RegMixEnable:  mix_q         <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign prod = 15'(frame_rate_q) * 15'(lines_q);

	// source rate is frames times lines times two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q   <= '0;
			limit_q <= '0;
		end else begin
			src_q <= {prod, 1'b0};
			if ({3'b0, spf_q} > arc_pkg::MaxFrameSamples) begin
				limit_q <= arc_pkg::MaxFrameSamples[arc_pkg::SpfW-1:0];
			end else begin
				limit_q <= spf_q;
			end
		end
	end

	assign cfg.output_rate = output_rate_q;
	assign cfg.mix_enable  = mix_q;
	assign cfg.src_rate    = src_q;
	assign cfg.limit       = limit_q;

endmodule

/* rtl/audio_rate_converter_mixer.sv */
// -----------------------------------------------------------------------------
// Audio rate converter and mixer
// Zero-order-hold phase accumulator converter with optional two-source mix.
// -----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carries one source step (two generator
// samples and a frame-start flag). Output channel: out_valid/out_stall carries
// zero to five output samples per step; last_of_run marks the final one.
// Config channel: cfg_valid/cfg_ready writes register cfg_index with cfg_data;
// cfg_ready is always high. Write only while no step is in progress.
// Sequence: a step is taken while idle, then the phase advance runs on the
// shared adder, then the emit tests run one after another on the same unit;
// the input is not ready again until an emit test fails and the sequencer
// returns to idle. The first output item is registered into the output
// register after the phase advance and its emit test.
// One output register holds the result; while it holds a valid item and
// out_stall is high, the sequencer holds and the input stays stalled.
// Reset: settings return to 48000 Hz output, 60 frames, 262 lines, 800
// samples per frame, mix off; the accumulator and per-frame output count clear.
// -----------------------------------------------------------------------------
module audio_rate_converter_mixer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [arc_pkg::SampleW-1:0] gen_a_sample,
	input  logic [arc_pkg::SampleW-1:0] gen_b_sample,
	input  logic                        frame_start,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [arc_pkg::SampleW-1:0] out_sample,
	output logic                        last_of_run,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [arc_pkg::IdxW-1:0]    cfg_index,
	input  logic [31:0]                 cfg_data
);

	localparam logic [1:0] StIdle  = 2'd0;
	localparam logic [1:0] StAcc   = 2'd1;
	localparam logic [1:0] StCheck = 2'd2;

	arc_pkg::cfg_t cfg;

	logic [1:0]                  state_q;
	logic [arc_pkg::AccW-1:0]    acc_q;
	logic [arc_pkg::SpfW-1:0]    cnt_q;
	logic [arc_pkg::NW-1:0]      n_q;
	logic                        pend_q;
	logic [arc_pkg::SampleW-1:0] a_q;
	logic [arc_pkg::SampleW-1:0] b_q;
	logic                        start_q;
	logic [arc_pkg::SampleW-1:0] sample_q;
	logic                        out_valid_q;
	logic [arc_pkg::SampleW-1:0] out_sample_q;
	logic                        out_last_q;

	logic                        in_accept;
	logic                        out_free;
	logic                        push;
	logic                        push_last;
	logic                        emit_ok;
	logic [arc_pkg::AccW-1:0]    alu_b;
	logic                        alu_sub;
	logic [arc_pkg::AccW:0]      alu_res;
	logic [arc_pkg::SampleW-1:0] mix_sum;

	assign cfg_ready = 1'b1;

	arc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	always_comb begin
		if (state_q == StCheck) begin
			alu_b   = {2'b0, cfg.src_rate};
			alu_sub = 1'b1;
		end else begin
			alu_b   = {1'b0, cfg.output_rate};
			alu_sub = 1'b0;
		end
	end

	arc_addsub u_alu (
		.a   (acc_q),
		.b   (alu_b),
		.sub (alu_sub),
		.res (alu_res)
	);

	assign in_stall  = (state_q != StIdle);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign mix_sum   = a_q + b_q;

	// no borrow means acc >= source rate
	assign emit_ok = !alu_res[arc_pkg::AccW] && (cnt_q < cfg.limit) && (n_q < arc_pkg::EmitMax);

	always_comb begin
		push      = 1'b0;
		push_last = 1'b0;
		if (state_q == StCheck && out_free && pend_q) begin
			push      = 1'b1;
			push_last = !emit_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			a_q <= gen_a_sample;
			b_q <= gen_b_sample;
		end
		if (state_q == StAcc) begin
			sample_q <= cfg.mix_enable ? (mix_sum >> 1) : a_q;
		end
		if (push) begin
			out_sample_q <= sample_q;
			out_last_q   <= push_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			acc_q       <= '0;
			cnt_q       <= '0;
			n_q         <= '0;
			pend_q      <= 1'b0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				StIdle: begin
					if (in_accept) begin
						start_q <= frame_start;
						state_q <= StAcc;
					end
				end
				StAcc: begin
					// reload on frame start, else advance with saturation
					if (start_q) begin
						acc_q <= {1'b0, cfg.output_rate};
						cnt_q <= '0;
					end else if (alu_res[arc_pkg::AccW]) begin
						acc_q <= arc_pkg::AccMax;
					end else begin
						acc_q <= alu_res[arc_pkg::AccW-1:0];
					end
					n_q     <= '0;
					pend_q  <= 1'b0;
					state_q <= StCheck;
				end
				StCheck: begin
					// hold until the output register can take the pending item
					if (out_free) begin
						if (emit_ok) begin
							acc_q  <= alu_res[arc_pkg::AccW-1:0];
							cnt_q  <= cnt_q + 1'b1;
							n_q    <= n_q + 1'b1;
							pend_q <= 1'b1;
						end else begin
							pend_q  <= 1'b0;
							state_q <= StIdle;
						end
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_sample  = out_sample_q;
	assign last_of_run = out_last_q;

`ifndef ASSERT_OFF
	a_accept_to_acc: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> state_q == StAcc)
		else $error("accepted step did not enter phase advance");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= arc_pkg::EmitMax)
		else $error("emit count exceeds per-step maximum");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_last |=> state_q == StIdle)
		else $error("last item pushed but sequencer kept running");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == StIdle |-> !pend_q)
		else $error("pending item left behind at idle");
`endif

endmodule
